// ===== design/efsif_pkg.sv =====
// Package with shared types and constants for the extended float integer/fraction split.
`timescale 1ns / 1ps
`default_nettype none
package efsif_pkg;
    localparam logic [14:0] EXP_ONE      = 15'h3fff;
    localparam logic [14:0] EXP_INTEGRAL = 15'h403e;
    localparam logic [14:0] EXP_MAX      = 15'h7fff;

    typedef enum logic [1:0] {
        CLS_LARGE,
        CLS_SMALL,
        CLS_SPLIT
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic        is_nan;
        logic [15:0] se;
        logic [63:0] sig;
        logic [63:0] mask;
    } t_job;

    localparam int JobW = $bits(t_job);
endpackage
`default_nettype wire

// ===== design/extended_float_split_int_frac.sv =====
// Top level of the 80-bit extended float integer/fraction split.
//  Channel | Direction | Fields
//  in      | input     | in_sign_exponent, in_significand
//  out     | output    | int/frac sign_exponent, int/frac significand
// One item per cycle sustained while the output is not stalled.
// Each item passes through the front register, queue, mask stage and normalize stage in order.
// Reset is synchronous and clears only valid and queue state.
// A stall on the output backs up through the queue to o_stall of the input.
`timescale 1ns / 1ps
`default_nettype none
module extended_float_split_int_frac
    import efsif_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_in_sign_exponent,
    input  wire logic [63:0] i_in_significand,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_int_sign_exponent,
    output logic [63:0]      o_int_significand,
    output logic [15:0]      o_frac_sign_exponent,
    output logic [63:0]      o_frac_significand
);
    logic f_valid;
    logic f_stall;
    t_job f_job;
    logic q_valid;
    logic q_stall;
    t_job q_job;

    efsif_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_in_sign_exponent, .i_in_significand,
        .o_valid(f_valid), .i_stall(f_stall), .o_job(f_job)
    );

    efsif_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(f_stall), .i_job(f_job),
        .o_valid(q_valid), .i_stall(q_stall), .o_job(q_job)
    );

    efsif_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_stall(q_stall), .i_job(q_job),
        .o_valid, .i_stall,
        .o_int_sign_exponent, .o_int_significand,
        .o_frac_sign_exponent, .o_frac_significand
    );

    a_sign_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_int_sign_exponent[15] == o_frac_sign_exponent[15])
        else $error("Integer and fraction signs differ.");
    a_frac_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frac_significand != 64'd0 && o_frac_sign_exponent[14:0] >= EXP_ONE
         && o_frac_sign_exponent[14:0] < EXP_INTEGRAL) |-> o_frac_significand[63])
        else $error("Fraction not normalized.");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("Result dropped while stalled.");
endmodule
`default_nettype wire

// ===== design/efsif_front.sv =====
// Front stage that accepts items, classifies them and builds the fraction mask.
`timescale 1ns / 1ps
`default_nettype none
module efsif_front
    import efsif_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_in_sign_exponent,
    input  wire logic [63:0] i_in_significand,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_job             o_job
);
    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic [14:0] ex;
    logic [6:0] nfrac;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_job   = r_job;
    assign ex      = i_in_sign_exponent[14:0];
    assign nfrac   = 7'(EXP_INTEGRAL - ex);

    always_comb begin
        n_job.se     = i_in_sign_exponent;
        n_job.sig    = i_in_significand;
        n_job.is_nan = (ex == EXP_MAX) && (i_in_significand[62:0] != 63'd0);
        n_job.mask   = 64'd0;
        if (ex >= EXP_INTEGRAL) begin
            n_job.cls = CLS_LARGE;
        end else if (ex < EXP_ONE) begin
            n_job.cls = CLS_SMALL;
        end else begin
            n_job.cls  = CLS_SPLIT;
            n_job.mask = (64'd1 << nfrac[5:0]) - 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule
`default_nettype wire

// ===== design/efsif_queue.sv =====
// Two-entry skid queue between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none
module efsif_queue
    import efsif_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_job      o_job
);
    t_job r_mem [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;
    logic push;
    logic pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

// ===== design/efsif_back.sv =====
// Back stages that mask, count leading zeros, normalize and register results.
`timescale 1ns / 1ps
`default_nettype none
module efsif_back
    import efsif_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  t_job             i_job,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_int_sign_exponent,
    output logic [63:0]      o_int_significand,
    output logic [15:0]      o_frac_sign_exponent,
    output logic [63:0]      o_frac_significand
);
    logic r_v1;
    logic r_v2;
    logic adv1;
    logic adv2;
    logic [15:0] r1_ise;
    logic [63:0] r1_isig;
    logic [15:0] r1_fse;
    logic [63:0] r1_rem;
    logic        r1_norm;
    logic [5:0]  lz;
    logic [63:0] rem;

    assign adv2    = !(r_v2 && i_stall);
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v2;
    assign rem     = i_job.sig & i_job.mask;

    always_comb begin
        lz = 6'd0;
        for (int k = 0; k < 64; k++) begin
            if (r1_rem[k]) lz = 6'(63 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            unique case (i_job.cls)
                CLS_LARGE: begin
                    r1_ise  <= i_job.se;
                    r1_isig <= i_job.sig;
                    r1_fse  <= i_job.is_nan ? i_job.se : {i_job.se[15], 15'd0};
                    r1_rem  <= i_job.is_nan ? i_job.sig : 64'd0;
                    r1_norm <= 1'b0;
                end
                CLS_SMALL: begin
                    r1_ise  <= {i_job.se[15], 15'd0};
                    r1_isig <= 64'd0;
                    r1_fse  <= i_job.se;
                    r1_rem  <= i_job.sig;
                    r1_norm <= 1'b0;
                end
                CLS_SPLIT: begin
                    r1_ise  <= i_job.se;
                    r1_isig <= i_job.sig & ~i_job.mask;
                    r1_fse  <= (rem == 64'd0) ? {i_job.se[15], 15'd0} : i_job.se;
                    r1_rem  <= rem;
                    r1_norm <= (rem != 64'd0);
                end
                default: begin
                    r1_ise  <= i_job.se;
                    r1_isig <= i_job.sig;
                    r1_fse  <= i_job.se;
                    r1_rem  <= rem;
                    r1_norm <= 1'b0;
                end
            endcase
        end
        if (adv2 && r_v1) begin
            o_int_sign_exponent <= r1_ise;
            o_int_significand   <= r1_isig;
            if (r1_norm) begin
                o_frac_sign_exponent <= {r1_fse[15], 15'(r1_fse[14:0] - {9'd0, lz})};
                o_frac_significand   <= r1_rem << lz;
            end else begin
                o_frac_sign_exponent <= r1_fse;
                o_frac_significand   <= r1_rem;
            end
        end
    end
endmodule
`default_nettype wire
